// ===== design/polygon_offset_varint_decoder_unit_assert.svh =====
// assertion macros shared by the decoder modules
`ifndef POLYGON_OFFSET_VARINT_DECODER_UNIT_ASSERT_SVH
`define POLYGON_OFFSET_VARINT_DECODER_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define POVD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition never holds
`define POVD_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== design/povd_pkg.sv =====
// types and constants of the polygon offset varint decoder
package povd_pkg;

    localparam int OUT_COORD_W = 64;
    localparam int OUT_COUNT_W = 32;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    typedef enum logic [2:0] {
        PH_MINX  = 3'd0,
        PH_MINY  = 3'd1,
        PH_NPOLY = 3'd2,
        PH_NPTS  = 3'd3,
        PH_RX    = 3'd4,
        PH_RY    = 3'd5,
        PH_DONE  = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        KIND_POINT = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_DONE  = 2'd2,
        KIND_ERROR = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_TRUNC = 2'd1,
        ERR_LONG  = 2'd2,
        ERR_TRAIL = 2'd3
    } err_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_end;
    } in_t;

    typedef struct packed {
        kind_t                          kind;
        err_t                           error_code;
        logic signed [OUT_COORD_W-1:0]  coord_x;
        logic signed [OUT_COORD_W-1:0]  coord_y;
        logic [OUT_COUNT_W-1:0]         polygon_index;
        logic [OUT_COUNT_W-1:0]         point_index;
        logic                           polygon_last;
        logic                           run_last;
    } out_t;

    // one queue entry: a first result (an item, or the end status alone) and an optional end status behind it
    typedef struct packed {
        out_t  first;
        logic  sec_valid;
        kind_t sec_kind;
        err_t  sec_err;
    } entry_t;

endpackage

// ===== design/povd_front.sv =====
// front end: varint assembly, phase tracking and result classification
`include "polygon_offset_varint_decoder_unit_assert.svh"

module povd_front #(
    parameter int COORD_WIDTH = 64,
    parameter int COUNT_WIDTH = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            byte_valid,
    output logic            byte_stall,
    input  povd_pkg::in_t   byte_data,
    output logic            push,
    output povd_pkg::entry_t entry,
    input  logic            full
);
    import povd_pkg::*;

    localparam int CW    = COORD_WIDTH;
    localparam int NW    = COUNT_WIDTH;
    localparam int ACC_W = (CW > NW) ? CW : NW;
    localparam int CNT_W = $clog2(ACC_W / 7 + 1);
    localparam int SH_W  = $clog2(ACC_W) + 2;

    phase_t           phase_reg, phase_next, phase_dec;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CW-1:0]    base_x_reg, base_x_next;
    logic [CW-1:0]    base_y_reg, base_y_next;
    logic [CW-1:0]    held_x_reg, held_x_next;
    logic [NW-1:0]    poly_left_reg, poly_left_next;
    logic [NW-1:0]    pts_left_reg, pts_left_next;
    logic [NW-1:0]    cur_poly_reg, cur_poly_next;
    logic [NW-1:0]    cur_pt_reg, cur_pt_next;
    logic             discard_reg, discard_next;

    logic             accept;
    logic             is_count;
    logic [SH_W-1:0]  width_w;
    logic [SH_W-1:0]  shift;
    logic [6:0]       bits;
    logic             cont;
    logic [ACC_W+6:0] ext;
    logic [ACC_W+6:0] ext_hi;
    logic             too_long;
    logic [ACC_W-1:0] val;
    logic [CW-1:0]    val_c;
    logic [NW-1:0]    val_n;
    logic [CW-1:0]    zz;
    logic             feed_done;
    logic             feed_more;
    logic [NW-1:0]    poly_dec;
    logic [NW-1:0]    pts_dec;
    logic             failed;
    logic [CW-1:0]    sum_x;
    logic [CW-1:0]    sum_y;
    logic             is_point;
    logic             is_marker;
    logic             has_item;
    logic             need_status;
    out_t             item_res;
    out_t             status_res;

    assign byte_stall = full;
    assign accept     = byte_valid && !full;

    // varint byte feed
    always_comb
    begin
        is_count = phase_reg inside {PH_NPOLY, PH_NPTS};
        width_w  = is_count ? SH_W'(NW) : SH_W'(CW);
        shift    = SH_W'(cnt_reg) * SH_W'(7);
        bits     = byte_data.payload_byte[6:0];
        cont     = byte_data.payload_byte[7];
        ext      = {{ACC_W{1'b0}}, bits} << shift;
        ext_hi   = ext >> width_w;
        too_long = (shift >= width_w) || (|ext_hi)
                   || (cont && ((shift + SH_W'(7)) >= width_w));
        val      = acc_reg | ext[ACC_W-1:0];
        val_c    = val[CW-1:0];
        val_n    = val[NW-1:0];
        zz       = (val_c >> 1) ^ {CW{val_c[0]}};
        feed_done = (phase_reg != PH_DONE) && !too_long && !cont;
        feed_more = (phase_reg != PH_DONE) && !too_long && cont;
        poly_dec  = poly_left_reg - NW'(1);
        pts_dec   = pts_left_reg - NW'(1);
        failed    = !discard_reg && ((phase_reg == PH_DONE) || too_long);
    end

    // phase after decoding this byte
    always_comb
    begin
        phase_dec = phase_reg;
        if (feed_done)
        begin
            case (phase_reg)
                PH_MINX:  phase_dec = PH_MINY;
                PH_MINY:  phase_dec = PH_NPOLY;
                PH_NPOLY: phase_dec = (val_n != '0) ? PH_NPTS : PH_DONE;
                PH_NPTS:
                begin
                    if (val_n == '0)
                        phase_dec = (poly_dec != '0) ? PH_NPTS : PH_DONE;
                    else
                        phase_dec = PH_RX;
                end
                PH_RX:    phase_dec = PH_RY;
                PH_RY:
                begin
                    if (pts_dec == '0)
                        phase_dec = (poly_dec != '0) ? PH_NPTS : PH_DONE;
                    else
                        phase_dec = PH_RX;
                end
                default:  phase_dec = PH_MINX;
            endcase
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            if (byte_data.payload_end)
                phase_next = PH_MINX;
            else if (!discard_reg)
                phase_next = phase_dec;
        end
    end

    // datapath state
    always_comb
    begin
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        base_x_next    = base_x_reg;
        base_y_next    = base_y_reg;
        held_x_next    = held_x_reg;
        poly_left_next = poly_left_reg;
        pts_left_next  = pts_left_reg;
        cur_poly_next  = cur_poly_reg;
        cur_pt_next    = cur_pt_reg;
        discard_next   = discard_reg;
        if (accept && !discard_reg)
        begin
            if (feed_more)
            begin
                acc_next = val;
                cnt_next = cnt_reg + CNT_W'(1);
            end
            if (feed_done)
            begin
                acc_next = '0;
                cnt_next = '0;
                case (phase_reg)
                    PH_MINX:  base_x_next = zz;
                    PH_MINY:  base_y_next = zz;
                    PH_NPOLY:
                    begin
                        poly_left_next = val_n;
                        cur_poly_next  = '0;
                    end
                    PH_NPTS:
                    begin
                        if (val_n == '0)
                        begin
                            cur_poly_next  = cur_poly_reg + NW'(1);
                            poly_left_next = poly_dec;
                        end
                        else
                        begin
                            pts_left_next = val_n;
                            cur_pt_next   = '0;
                        end
                    end
                    PH_RX:    held_x_next = val_c;
                    PH_RY:
                    begin
                        pts_left_next = pts_dec;
                        cur_pt_next   = cur_pt_reg + NW'(1);
                        if (pts_dec == '0)
                        begin
                            cur_poly_next  = cur_poly_reg + NW'(1);
                            poly_left_next = poly_dec;
                        end
                    end
                    default: ;
                endcase
            end
            if (failed && !byte_data.payload_end)
                discard_next = 1'b1;
        end
        // the final byte always starts a fresh payload
        if (accept && byte_data.payload_end)
        begin
            acc_next       = '0;
            cnt_next       = '0;
            base_x_next    = '0;
            base_y_next    = '0;
            held_x_next    = '0;
            poly_left_next = '0;
            pts_left_next  = '0;
            cur_poly_next  = '0;
            cur_pt_next    = '0;
            discard_next   = 1'b0;
        end
    end

    // queue entry
    always_comb
    begin
        sum_x       = base_x_reg + held_x_reg;
        sum_y       = base_y_reg + val_c;
        is_point    = feed_done && (phase_reg == PH_RY);
        is_marker   = feed_done && (phase_reg == PH_NPTS) && (val_n == '0);
        has_item    = failed || is_point || is_marker;
        need_status = byte_data.payload_end && !failed;

        item_res = '0;
        if (phase_reg == PH_DONE)
        begin
            item_res.kind       = KIND_ERROR;
            item_res.error_code = ERR_TRAIL;
        end
        else if (too_long)
        begin
            item_res.kind       = KIND_ERROR;
            item_res.error_code = ERR_LONG;
        end
        else if (is_point)
        begin
            item_res.kind          = KIND_POINT;
            item_res.coord_x       = OUT_COORD_W'($signed(sum_x));
            item_res.coord_y       = OUT_COORD_W'($signed(sum_y));
            item_res.polygon_index = OUT_COUNT_W'(cur_poly_reg);
            item_res.point_index   = OUT_COUNT_W'(cur_pt_reg);
            item_res.polygon_last  = (pts_left_reg == NW'(1));
        end
        else
        begin
            item_res.kind          = KIND_EMPTY;
            item_res.polygon_index = OUT_COUNT_W'(cur_poly_reg);
        end

        status_res = '0;
        if (phase_dec == PH_DONE)
            status_res.kind = KIND_DONE;
        else
        begin
            status_res.kind       = KIND_ERROR;
            status_res.error_code = ERR_TRUNC;
        end

        push            = accept && !discard_reg && (has_item || byte_data.payload_end);
        entry.first     = has_item ? item_res : status_res;
        entry.sec_valid = has_item && need_status;
        entry.sec_kind  = status_res.kind;
        entry.sec_err   = status_res.error_code;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_MINX;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            base_x_reg    <= '0;
            base_y_reg    <= '0;
            held_x_reg    <= '0;
            poly_left_reg <= '0;
            pts_left_reg  <= '0;
            cur_poly_reg  <= '0;
            cur_pt_reg    <= '0;
            discard_reg   <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            base_x_reg    <= base_x_next;
            base_y_reg    <= base_y_next;
            held_x_reg    <= held_x_next;
            poly_left_reg <= poly_left_next;
            pts_left_reg  <= pts_left_next;
            cur_poly_reg  <= cur_poly_next;
            cur_pt_reg    <= cur_pt_next;
            discard_reg   <= discard_next;
        end
    end

    `POVD_ASSERT_IMP(a_discard_silent, discard_reg, !push, "result pushed while dropping bytes")

endmodule

// ===== design/povd_fifo.sv =====
// short queue of result entries between front and back end
`include "polygon_offset_varint_decoder_unit_assert.svh"

module povd_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  povd_pkg::entry_t wr_entry,
    input  logic             pop,
    output povd_pkg::entry_t head,
    output logic             empty,
    output logic             full
);
    import povd_pkg::*;

    entry_t            mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == QCNT_W'(QDEPTH));
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `POVD_ASSERT_IMP(a_push_room, push, !full, "push into a full queue")
    `POVD_ASSERT_IMP(a_pop_data, pop, !empty, "pop from an empty queue")

endmodule

// ===== design/povd_back.sv =====
// back end: splits queue entries into single results behind an output register
`include "polygon_offset_varint_decoder_unit_assert.svh"

module povd_back (
    input  logic             clk,
    input  logic             rst_n,
    input  povd_pkg::entry_t head,
    input  logic             head_valid,
    output logic             pop,
    output logic             result_valid,
    input  logic             result_stall,
    output povd_pkg::out_t   result_data
);
    import povd_pkg::*;

    logic valid_reg, valid_next;
    logic sec_pend_reg, sec_pend_next;
    out_t data_reg, data_next;
    logic load;
    out_t status_res;

    assign result_valid = valid_reg;
    assign result_data  = data_reg;

    always_comb
    begin
        load = !valid_reg || !result_stall;
        pop  = load && head_valid && (sec_pend_reg || !head.sec_valid);

        status_res            = '0;
        status_res.kind       = head.sec_kind;
        status_res.error_code = head.sec_err;
        status_res.run_last   = 1'b1;

        valid_next    = valid_reg;
        sec_pend_next = sec_pend_reg;
        data_next     = data_reg;
        if (load)
        begin
            valid_next    = head_valid;
            sec_pend_next = head_valid && !sec_pend_reg && head.sec_valid;
            if (sec_pend_reg)
                data_next = status_res;
            else
            begin
                data_next          = head.first;
                data_next.run_last = !head.sec_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            sec_pend_reg <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            sec_pend_reg <= sec_pend_next;
        end
    end

    `POVD_ASSERT_IMP(a_pend_has_head, sec_pend_reg, head_valid, "second half pending without entry")
    `POVD_ASSERT_IMP(a_split_pending, valid_reg && !data_reg.run_last, sec_pend_reg, "non-final result without pending status")

endmodule

// ===== design/polygon_offset_varint_decoder_unit.sv =====
// top level of the polygon offset varint decoder
//
// byte channel: one payload byte per transfer, payload_end set on the last byte
// of a payload. result channel: one decoded result per transfer (point, empty
// polygon marker, done status or error); run_last marks the last result of a
// byte. both channels move a transfer when valid is high and stall is low.
//
// a byte is taken every cycle while the four-entry result queue has room; the
// varint assembly and phase update of one byte are combinational, so the
// sustained rate is one byte per cycle. a byte with two results (an item and
// the end status) sends them from the output register one after the other;
// its first result passes through the queue and then the output register.
//
// reset clears the decoder to the start of a payload and empties the queue.
// when the receiver stalls, the output register holds its result, the queue
// fills and byte_stall rises once it is full.
module polygon_offset_varint_decoder_unit #(
    parameter int COORD_WIDTH = 64,
    parameter int COUNT_WIDTH = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           byte_valid,
    output logic           byte_stall,
    input  povd_pkg::in_t  byte_data,
    output logic           result_valid,
    input  logic           result_stall,
    output povd_pkg::out_t result_data
);
    import povd_pkg::*;

    logic   push;
    logic   pop;
    logic   empty;
    logic   full;
    entry_t wr_entry;
    entry_t head;

    povd_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .push       (push),
        .entry      (wr_entry),
        .full       (full)
    );

    povd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (wr_entry),
        .pop      (pop),
        .head     (head),
        .empty    (empty),
        .full     (full)
    );

    povd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .head_valid   (!empty),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

endmodule

// ===== verif/tb_polygon_offset_varint_decoder_unit.sv =====
// self-checking testbench for the polygon offset varint decoder
`timescale 1ns / 1ps

module tb_polygon_offset_varint_decoder_unit;
    import povd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        in_t data;
        bit  hold;
    } queued_byte_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic byte_valid = 1'b0;
    logic byte_stall;
    in_t byte_data = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    out_t result_data;

    queued_byte_t byte_queue[$];
    out_t awaited_results[$];
    logic [7:0] frame[$];
    bit byte_taken = 1'b0;
    int byte_gap_pct = 0;
    int result_hold_pct = 0;
    int fail_count = 0;
    int cycle_count = 0;

    // payload builder state
    int bad_at;
    int vidx;
    bit stop_frame;

    // decoder state as the predictor sees it
    phase_t ph;
    logic [63:0] vacc;
    int vcount;
    logic [63:0] base_x;
    logic [63:0] base_y;
    logic [63:0] held_x;
    logic [31:0] polys_left;
    logic [31:0] pts_left;
    logic [31:0] cur_poly;
    logic [31:0] cur_pt;
    bit dropping;

    polygon_offset_varint_decoder_unit uut (
        .clk(clk),
        .rst_n(rst_n),
        .byte_valid(byte_valid),
        .byte_stall(byte_stall),
        .byte_data(byte_data),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result_data(result_data)
    );

    always #4 clk = ~clk;

    function automatic out_t mk_result(kind_t k, err_t e, logic [63:0] x, logic [63:0] y,
                                       logic [31:0] pg, logic [31:0] pt, logic pl);
        out_t r;
        r.kind = k;
        r.error_code = e;
        r.coord_x = x;
        r.coord_y = y;
        r.polygon_index = pg;
        r.point_index = pt;
        r.polygon_last = pl;
        r.run_last = 1'b0;
        return r;
    endfunction

    task automatic reset_decoder();
        ph = PH_MINX;
        vacc = '0;
        vcount = 0;
        base_x = '0;
        base_y = '0;
        held_x = '0;
        polys_left = '0;
        pts_left = '0;
        cur_poly = '0;
        cur_pt = '0;
        dropping = 1'b0;
    endtask

    task automatic close_polygon();
        cur_poly++;
        polys_left--;
        ph = (polys_left != 0) ? PH_NPTS : PH_DONE;
    endtask

    // works out the results one accepted byte causes and queues them
    task automatic decode_payload_byte(input in_t b);
        out_t res[$];
        out_t r;
        logic [63:0] v;
        logic [6:0] bits;
        int w;
        int sh;
        bit cont;
        bit failed;
        bit too_long;
        failed = 1'b0;
        if (dropping) begin
            if (b.payload_end)
                reset_decoder();
            return;
        end
        if (ph == PH_DONE) begin
            res.push_back(mk_result(KIND_ERROR, ERR_TRAIL, '0, '0, '0, '0, 1'b0));
            failed = 1'b1;
        end else begin
            w = (ph == PH_NPOLY || ph == PH_NPTS) ? 32 : 64;
            sh = 7 * vcount;
            bits = b.payload_byte[6:0];
            cont = b.payload_byte[7];
            too_long = (sh >= w) || ((w - sh < 7) && ((bits >> (w - sh)) != 0))
                       || (cont && sh + 7 >= w);
            if (too_long) begin
                res.push_back(mk_result(KIND_ERROR, ERR_LONG, '0, '0, '0, '0, 1'b0));
                failed = 1'b1;
            end else begin
                vacc = vacc | (64'(bits) << sh);
                if (cont) begin
                    vcount++;
                end else begin
                    v = vacc;
                    vacc = '0;
                    vcount = 0;
                    case (ph)
                        PH_MINX: begin
                            base_x = (v >> 1) ^ {64{v[0]}};
                            ph = PH_MINY;
                        end
                        PH_MINY: begin
                            base_y = (v >> 1) ^ {64{v[0]}};
                            ph = PH_NPOLY;
                        end
                        PH_NPOLY: begin
                            polys_left = v[31:0];
                            cur_poly = '0;
                            ph = (polys_left != 0) ? PH_NPTS : PH_DONE;
                        end
                        PH_NPTS: begin
                            if (v == 0) begin
                                res.push_back(mk_result(KIND_EMPTY, ERR_NONE, '0, '0,
                                                        cur_poly, '0, 1'b0));
                                close_polygon();
                            end else begin
                                pts_left = v[31:0];
                                cur_pt = '0;
                                ph = PH_RX;
                            end
                        end
                        PH_RX: begin
                            held_x = v;
                            ph = PH_RY;
                        end
                        default: begin
                            res.push_back(mk_result(KIND_POINT, ERR_NONE, base_x + held_x,
                                                    base_y + v, cur_poly, cur_pt,
                                                    pts_left == 1));
                            pts_left--;
                            cur_pt++;
                            if (pts_left == 0)
                                close_polygon();
                            else
                                ph = PH_RX;
                        end
                    endcase
                end
            end
        end
        if (b.payload_end) begin
            if (!failed) begin
                if (ph == PH_DONE)
                    res.push_back(mk_result(KIND_DONE, ERR_NONE, '0, '0, '0, '0, 1'b0));
                else
                    res.push_back(mk_result(KIND_ERROR, ERR_TRUNC, '0, '0, '0, '0, 1'b0));
            end
            reset_decoder();
        end else if (failed) begin
            dropping = 1'b1;
        end
        foreach (res[i]) begin
            r = res[i];
            r.run_last = (i == res.size() - 1);
            awaited_results.push_back(r);
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    function automatic logic [63:0] zigzag(logic [63:0] v);
        return {v[62:0], 1'b0} ^ {64{v[63]}};
    endfunction

    function automatic logic [63:0] pick_coord();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return 64'h0;
            1: return 64'hFFFF_FFFF_FFFF_FFFF;
            2: return 64'h8000_0000_0000_0000;
            3: return 64'h7FFF_FFFF_FFFF_FFFF;
            4, 5, 6: return 64'($urandom_range(0, 300));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [31:0] pick_count();
        int r;
        r = $urandom_range(0, 19);
        if (r < 3)
            return 32'h0;
        else if (r < 17)
            return 32'($urandom_range(1, 3));
        else if (r == 17)
            return 32'd4;
        else if (r == 18)
            return $urandom;
        else
            return 32'hFFFF_FFFF;
    endfunction

    // appends one varint, sometimes padded, or an overlong one where bad_at points
    task automatic put_varint(input logic [63:0] v, input int w);
        int len;
        int maxlen;
        logic [63:0] rest;
        if (stop_frame)
            return;
        maxlen = (w + 6) / 7;
        if (vidx == bad_at) begin
            repeat (maxlen - 1) frame.push_back(8'h80 | 8'($urandom_range(0, 127)));
            if ($urandom_range(0, 1))
                frame.push_back(8'h80 | 8'($urandom_range(0, 127)));
            else
                frame.push_back(8'($urandom_range((w == 64) ? 2 : 16, 127)));
            repeat ($urandom_range(0, 3)) frame.push_back(8'($urandom_range(0, 255)));
            stop_frame = 1'b1;
        end else begin
            len = 1;
            rest = v >> 7;
            while (rest != 0) begin
                len++;
                rest = rest >> 7;
            end
            if ($urandom_range(0, 9) == 0)
                len = $urandom_range(len, maxlen);
            for (int i = 0; i < len; i++)
                frame.push_back({(i < len - 1) ? 1'b1 : 1'b0, 7'(v >> (7 * i))});
        end
        vidx++;
    endtask

    task automatic build_payload(input int bad);
        logic [31:0] np;
        logic [31:0] nq;
        bad_at = bad;
        vidx = 0;
        stop_frame = 1'b0;
        put_varint(zigzag(pick_coord()), 64);
        put_varint(zigzag(pick_coord()), 64);
        np = pick_count();
        put_varint(64'(np), 32);
        // huge counts are cut short and end up truncated
        for (int p = 0; p < np && p < 4; p++) begin
            nq = pick_count();
            put_varint(64'(nq), 32);
            for (int q = 0; q < nq && q < 4; q++) begin
                put_varint(pick_coord(), 64);
                put_varint(pick_coord(), 64);
            end
        end
    endtask

    task automatic send_frame(input bit hold);
        queued_byte_t qb;
        foreach (frame[i]) begin
            qb.data.payload_byte = frame[i];
            qb.data.payload_end = (i == frame.size() - 1);
            qb.hold = hold && (i == 0);
            byte_queue.push_back(qb);
        end
    endtask

    task automatic random_payloads(input int target, input bit hold_first);
        int sent;
        int mode;
        bit hold;
        sent = 0;
        hold = hold_first;
        while (sent < target) begin
            mode = $urandom_range(0, 99);
            frame = {};
            if (mode < 90) begin
                build_payload((mode >= 75) ? $urandom_range(0, 8) : -1);
            end else begin
                repeat ($urandom_range(1, 12)) frame.push_back(8'($urandom_range(0, 255)));
            end
            // truncated payloads
            if (mode >= 55 && mode < 67 && frame.size() > 1)
                frame = frame[0:$urandom_range(0, frame.size() - 2)];
            // trailing bytes after a complete structure
            if (mode >= 67 && mode < 75)
                repeat ($urandom_range(1, 3)) frame.push_back(8'($urandom_range(0, 255)));
            sent += frame.size();
            send_frame(hold);
            hold = 1'b0;
        end
    endtask

    task automatic wait_bytes_sent();
        while (byte_queue.size() != 0 || byte_valid)
            @(posedge clk);
    endtask

    // byte driver
    always @(negedge clk) begin
        queued_byte_t qb;
        bit go;
        if (rst_n) begin
            if (!byte_valid || byte_taken) begin
                go = 1'b0;
                if (byte_queue.size() != 0 && $urandom_range(0, 99) >= byte_gap_pct)
                    go = !byte_queue[0].hold || awaited_results.size() == 0;
                if (go) begin
                    qb = byte_queue.pop_front();
                    byte_data <= qb.data;
                end
                byte_valid <= go;
            end
            result_stall <= ($urandom_range(0, 99) < result_hold_pct);
        end
    end

    // transfer monitor and result checker
    always @(posedge clk) begin
        out_t want;
        if (rst_n) begin
            byte_taken <= byte_valid && !byte_stall;
            if (byte_valid && !byte_stall)
                decode_payload_byte(byte_data);
            if (result_valid && !result_stall) begin
                if (awaited_results.size() == 0) begin
                    $error("unexpected result: kind %0d error_code %0d",
                           result_data.kind, result_data.error_code);
                    fail_count++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("kind", want.kind, result_data.kind);
                    check_field("error_code", want.error_code, result_data.error_code);
                    check_field("coord_x", want.coord_x, result_data.coord_x);
                    check_field("coord_y", want.coord_y, result_data.coord_y);
                    check_field("polygon_index", want.polygon_index,
                                result_data.polygon_index);
                    check_field("point_index", want.point_index, result_data.point_index);
                    check_field("polygon_last", want.polygon_last, result_data.polygon_last);
                    check_field("run_last", want.run_last, result_data.run_last);
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        reset_decoder();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: marker then closing point, wrap of negative base, done
        frame = {8'hFF, 8'h01, 8'h00, 8'h02, 8'h00, 8'h01, 8'h01, 8'h02};
        send_frame(1'b0);
        // trailing byte after zero polygons, then a dropped byte
        frame = {8'h00, 8'h00, 8'h00, 8'hFF, 8'h55};
        send_frame(1'b0);
        // truncated in the middle of a varint
        frame = {8'h80};
        send_frame(1'b0);
        // overlong polygon count
        frame = {8'h00, 8'h00, 8'h80, 8'h80, 8'h80, 8'h80, 8'h10};
        send_frame(1'b0);
        // point completed on the final byte, then truncation
        frame = {8'h00, 8'h00, 8'h01, 8'h02, 8'h03, 8'h04};
        send_frame(1'b0);

        // first random payload waits until the directed results have drained
        random_payloads(400, 1'b1);
        wait_bytes_sent();

        byte_gap_pct = 86;
        result_hold_pct = 0;
        random_payloads(350, 1'b0);
        wait_bytes_sent();

        byte_gap_pct = 0;
        result_hold_pct = 86;
        random_payloads(350, 1'b0);
        wait_bytes_sent();

        byte_gap_pct = 19;
        result_hold_pct = 19;
        random_payloads(200, 1'b0);
        random_payloads(200, 1'b1);
        wait_bytes_sent();

        byte_gap_pct = 0;
        result_hold_pct = 0;
        random_payloads(400, 1'b0);
        wait_bytes_sent();

        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== polygon_offset_varint_decoder_unit.f =====
+incdir+design
design/povd_pkg.sv
design/povd_front.sv
design/povd_fifo.sv
design/povd_back.sv
design/polygon_offset_varint_decoder_unit.sv
verif/tb_polygon_offset_varint_decoder_unit.sv
